/* rtl/ec_pkg.sv */
// Package: shared types, command codes and calendar constants for the epoch converter.
`timescale 1ns / 1ps
`default_nettype none
package ec_pkg;

	localparam int TIME_W  = 32;
	localparam int ZONE_W  = 5;
	localparam int DAYS_W  = 16;
	localparam int REM_W   = 6;
	localparam int SEC_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int WDAY_W  = 3;
	localparam int YEAR_W  = 8;
	localparam int YDAY_W  = 9;
	localparam int MON_W   = 4;
	localparam int MDAY_W  = 5;

	localparam logic [ZONE_W-1:0] ZONE_RESET = 5'd9;
	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 8'd70;
	localparam logic [YEAR_W-1:0] YEAR_2100  = 8'd200;
	localparam logic [MON_W-1:0]  MON_LAST   = 4'd11;

	localparam logic [DAYS_W-1:0] DAYS_YEAR = 16'd365;
	localparam logic [DAYS_W-1:0] DAYS_LEAP = 16'd366;
	localparam logic [TIME_W-1:0] EPOCH_WDAY = 32'd4;

	// divisor / remainder destination select
	localparam logic [1:0] SEL_SEC  = 2'd0;
	localparam logic [1:0] SEL_MIN  = 2'd1;
	localparam logic [1:0] SEL_HOUR = 2'd2;
	localparam logic [1:0] SEL_WDAY = 2'd3;

	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_LOAD  = 3'd1;
	localparam logic [2:0] OP_DIV   = 3'd2;
	localparam logic [2:0] OP_TAKE  = 3'd3;
	localparam logic [2:0] OP_YEAR  = 3'd4;
	localparam logic [2:0] OP_YDONE = 3'd5;
	localparam logic [2:0] OP_MONTH = 3'd6;
	localparam logic [2:0] OP_PUSH  = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic year_more;
		logic month_more;
		logic out_stall;
	} sts_t;

	function automatic logic [REM_W-1:0] divisor(input logic [1:0] sel);
		case (sel)
			SEL_SEC:  divisor = 6'd60;
			SEL_MIN:  divisor = 6'd60;
			SEL_HOUR: divisor = 6'd24;
			default:  divisor = 6'd7;
		endcase
	endfunction

	// reciprocal multipliers; the product is shifted right by 37, 37, 36 and 34
	function automatic logic [TIME_W-1:0] recip(input logic [1:0] sel);
		case (sel)
			SEL_SEC:  recip = 32'h8888_8889;
			SEL_MIN:  recip = 32'h8888_8889;
			SEL_HOUR: recip = 32'hAAAA_AAAB;
			default:  recip = 32'h9249_2493;
		endcase
	endfunction

	function automatic logic [MDAY_W-1:0] month_days(input logic [MON_W-1:0] m,
		input logic leap);
		case (m)
			4'd0:    month_days = 5'd31;
			4'd1:    month_days = leap ? 5'd29 : 5'd28;
			4'd2:    month_days = 5'd31;
			4'd3:    month_days = 5'd30;
			4'd4:    month_days = 5'd31;
			4'd5:    month_days = 5'd30;
			4'd6:    month_days = 5'd31;
			4'd7:    month_days = 5'd31;
			4'd8:    month_days = 5'd30;
			4'd9:    month_days = 5'd31;
			4'd10:   month_days = 5'd30;
			default: month_days = 5'd31;
		endcase
	endfunction

endpackage
`default_nettype wire

/* rtl/ec_if.sv */
// Interfaces: input time-stamp channel and calendar result channel.
`timescale 1ns / 1ps
`default_nettype none
interface ec_in_if;
	logic                      valid;
	logic                      ready;
	logic [ec_pkg::TIME_W-1:0] epoch_seconds;
	logic                      to_local;

	modport source (output valid, output epoch_seconds, output to_local, input ready);
	modport sink   (input valid, input epoch_seconds, input to_local, output ready);
endinterface

interface ec_out_if;
	logic                      valid;
	logic                      ready;
	logic [ec_pkg::SEC_W-1:0]  second;
	logic [ec_pkg::SEC_W-1:0]  minute;
	logic [ec_pkg::HOUR_W-1:0] hour;
	logic [ec_pkg::WDAY_W-1:0] weekday;
	logic [ec_pkg::YEAR_W-1:0] year_since_1900;
	logic [ec_pkg::YDAY_W-1:0] day_of_year;
	logic [ec_pkg::MON_W-1:0]  month;
	logic [ec_pkg::MDAY_W-1:0] day_of_month;

	modport source (output valid, output second, output minute, output hour, output weekday,
		output year_since_1900, output day_of_year, output month, output day_of_month,
		input ready);
	modport sink   (input valid, input second, input minute, input hour, input weekday,
		input year_since_1900, input day_of_year, input month, input day_of_month,
		output ready);
endinterface
`default_nettype wire

/* rtl/ec_ctrl.sv */
// Controller: sequences load, four reciprocal divisions, year walk, month walk and result push.
`timescale 1ns / 1ps
`default_nettype none
module ec_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire ec_pkg::sts_t sts,
	output ec_pkg::cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_TAKE  = 3'd2;
	localparam logic [2:0] ST_YEAR  = 3'd3;
	localparam logic [2:0] ST_MONTH = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]               state_q, state_d;
	logic [1:0]               sel_q, sel_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd.op  = ec_pkg::OP_NONE;
		cmd.sel = sel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = ec_pkg::OP_LOAD;
					sel_d   = ec_pkg::SEL_SEC;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.op  = ec_pkg::OP_DIV;
				state_d = ST_TAKE;
			end
			ST_TAKE: begin
				cmd.op = ec_pkg::OP_TAKE;
				if (sel_q == ec_pkg::SEL_WDAY) begin
					state_d = ST_YEAR;
				end else begin
					sel_d   = sel_q + 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_YEAR: begin
				if (sts.year_more) begin
					cmd.op = ec_pkg::OP_YEAR;
				end else begin
					cmd.op  = ec_pkg::OP_YDONE;
					state_d = ST_MONTH;
				end
			end
			ST_MONTH: begin
				if (sts.month_more) cmd.op = ec_pkg::OP_MONTH;
				else state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_stall) begin
					cmd.op  = ec_pkg::OP_PUSH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= ec_pkg::SEL_SEC;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/ec_datapath.sv */
// Datapath: zone offset, shared reciprocal divider, year and month walk, result register.
`timescale 1ns / 1ps
`default_nettype none
module ec_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ec_pkg::ZONE_W-1:0]   cfg_wdata,
	input  wire logic [ec_pkg::TIME_W-1:0]   epoch_seconds,
	input  wire logic                        to_local,
	input  wire ec_pkg::cmd_t                cmd,
	output ec_pkg::sts_t                     sts,
	ec_out_if.source                         cal
);

	logic [ec_pkg::ZONE_W-1:0] zone_q;
	logic [ec_pkg::TIME_W-1:0] t_q;
	logic [ec_pkg::TIME_W-1:0] quo_q;
	logic [ec_pkg::DAYS_W-1:0] days_q;
	logic [ec_pkg::YEAR_W-1:0] year_q;
	logic [ec_pkg::MON_W-1:0]  mon_q;
	logic [ec_pkg::SEC_W-1:0]  sec_q, min_q;
	logic [ec_pkg::HOUR_W-1:0] hour_q;
	logic [ec_pkg::WDAY_W-1:0] wday_q;
	logic [ec_pkg::YDAY_W-1:0] yday_q;
	logic                      out_valid_q;

	logic signed [16:0]          ofs_s;
	logic [ec_pkg::TIME_W-1:0]   ofs_add;
	logic [2*ec_pkg::TIME_W-1:0] prod;
	logic [ec_pkg::TIME_W-1:0]   quo;
	logic [2*ec_pkg::REM_W-1:0]  qd;
	logic [ec_pkg::REM_W-1:0]    rem;
	logic                        leap;
	logic [ec_pkg::DAYS_W-1:0]   diy;
	logic [ec_pkg::DAYS_W-1:0]   dim;

	assign ofs_s   = $signed({{12{zone_q[ec_pkg::ZONE_W-1]}}, zone_q}) * 17'sd3600;
	assign ofs_add = to_local ? {{15{ofs_s[16]}}, ofs_s} : '0;

	// quotient by reciprocal multiply, exact over the operand range of each step
	assign prod = t_q * ec_pkg::recip(cmd.sel);

	always_comb begin
		case (cmd.sel)
			ec_pkg::SEL_SEC, ec_pkg::SEL_MIN: quo = {5'd0, prod[63:37]};
			ec_pkg::SEL_HOUR:                 quo = {4'd0, prod[63:36]};
			default:                          quo = {2'd0, prod[63:34]};
		endcase
	end

	// remainder is below 64, so six bits of the difference are enough
	assign qd  = quo_q[ec_pkg::REM_W-1:0] * ec_pkg::divisor(cmd.sel);
	assign rem = t_q[ec_pkg::REM_W-1:0] - qd[ec_pkg::REM_W-1:0];

	// Gregorian rule over 1970..2106: only 2100 is a skipped century
	assign leap = (year_q[1:0] == 2'b00) && (year_q != ec_pkg::YEAR_2100);
	assign diy  = leap ? ec_pkg::DAYS_LEAP : ec_pkg::DAYS_YEAR;
	assign dim  = {{(ec_pkg::DAYS_W-ec_pkg::MDAY_W){1'b0}}, ec_pkg::month_days(mon_q, leap)};

	assign sts.year_more  = (days_q >= diy);
	assign sts.month_more = (mon_q != ec_pkg::MON_LAST) && (days_q >= dim);
	assign sts.out_stall  = out_valid_q && !cal.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) zone_q <= ec_pkg::ZONE_RESET;
		else if (cfg_we) zone_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ec_pkg::OP_LOAD: begin
				t_q    <= epoch_seconds + ofs_add;
				year_q <= ec_pkg::EPOCH_YEAR;
				mon_q  <= '0;
			end
			ec_pkg::OP_DIV: quo_q <= quo;
			ec_pkg::OP_TAKE: begin
				t_q <= (cmd.sel == ec_pkg::SEL_HOUR) ? quo_q + ec_pkg::EPOCH_WDAY : quo_q;
				case (cmd.sel)
					ec_pkg::SEL_SEC: sec_q <= rem;
					ec_pkg::SEL_MIN: min_q <= rem;
					ec_pkg::SEL_HOUR: begin
						hour_q <= rem[ec_pkg::HOUR_W-1:0];
						days_q <= quo_q[ec_pkg::DAYS_W-1:0];
					end
					default: wday_q <= rem[ec_pkg::WDAY_W-1:0];
				endcase
			end
			ec_pkg::OP_YEAR: begin
				days_q <= days_q - diy;
				year_q <= year_q + 1'b1;
			end
			ec_pkg::OP_YDONE: yday_q <= days_q[ec_pkg::YDAY_W-1:0];
			ec_pkg::OP_MONTH: begin
				days_q <= days_q - dim;
				mon_q  <= mon_q + 1'b1;
			end
			ec_pkg::OP_PUSH: begin
				cal.second          <= sec_q;
				cal.minute          <= min_q;
				cal.hour            <= hour_q;
				cal.weekday         <= wday_q;
				cal.year_since_1900 <= year_q;
				cal.day_of_year     <= yday_q;
				cal.month           <= mon_q;
				cal.day_of_month    <= ec_pkg::MDAY_W'(days_q + 1'b1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.op == ec_pkg::OP_PUSH) out_valid_q <= 1'b1;
		else if (cal.ready) out_valid_q <= 1'b0;
	end

	assign cal.valid = out_valid_q;

endmodule
`default_nettype wire

/* rtl/epoch_to_calendar_top.sv */
// Top level: epoch seconds to Gregorian calendar converter.
`timescale 1ns / 1ps
`default_nettype none
// Converts unsigned 32-bit epoch seconds (optionally shifted by the signed zone offset in
// hours, wrapping modulo 2^32) into second, minute, hour, weekday, year since 1900, day of
// year, month and day of month. One beat is worked on at a time: four divisions (by 60,
// 60, 24 and 7), each a divide step and a take step through one shared reciprocal
// multiplier, then a year walk with one step per year past 1970 (Y) and a month walk with
// one step per zero-based month (M), each walk closed by a step of its own, and last the
// load of the result. Y + M is at most 146 (December 2105). The result sits in an output
// register and the input is ready again the cycle after it is loaded, so the next beat is
// taken while a finished result waits; a second result is held until the first is taken.
// cfg_we writes the signed zone offset in hours from cfg_wdata.
module epoch_to_calendar_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [ec_pkg::ZONE_W-1:0] cfg_wdata,
	ec_in_if.sink                          stamp,
	ec_out_if.source                       cal
);

	ec_pkg::cmd_t cmd;
	ec_pkg::sts_t sts;

	ec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stamp.valid),
		.in_ready (stamp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ec_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.epoch_seconds (stamp.epoch_seconds),
		.to_local      (stamp.to_local),
		.cmd           (cmd),
		.sts           (sts),
		.cal           (cal)
	);

endmodule
`default_nettype wire

/* verif/tb_epoch_to_calendar_top.sv */
// Testbench: epoch seconds to calendar converter, self-checking against a behavioral predictor.
`timescale 1ns / 1ps
module tb_epoch_to_calendar_top;

	localparam int CYCLE_LIMIT   = 4000000;
	localparam int SEC_PER_HOUR  = 3600;
	localparam int SEC_PER_DAY   = 86400;
	localparam int FIRST_YEAR    = 1970;
	localparam int YEAR_BASE     = 1900;
	localparam int DRAIN_CYCLES  = 300;
	localparam int HOLD_CYCLES   = 700;
	localparam int MAX_REPORTS   = 100;

	typedef struct packed {
		logic [ec_pkg::SEC_W-1:0]  second;
		logic [ec_pkg::SEC_W-1:0]  minute;
		logic [ec_pkg::HOUR_W-1:0] hour;
		logic [ec_pkg::WDAY_W-1:0] weekday;
		logic [ec_pkg::YEAR_W-1:0] year_since_1900;
		logic [ec_pkg::YDAY_W-1:0] day_of_year;
		logic [ec_pkg::MON_W-1:0]  month;
		logic [ec_pkg::MDAY_W-1:0] day_of_month;
	} cal_t;

	typedef struct {
		logic [ec_pkg::TIME_W-1:0] stamp;
		logic                      lcl;
		cal_t                      cal;
	} due_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [ec_pkg::ZONE_W-1:0]   cfg_wdata;
	logic [ec_pkg::ZONE_W-1:0]   zone_now = ec_pkg::ZONE_RESET;
	due_t                        pending[$];
	int                          fail_count = 0;
	int                          cycles = 0;
	int                          hold_req = 0;
	bit                          steady = 1'b0;

	ec_in_if  stamp_if ();
	ec_out_if cal_if ();

	epoch_to_calendar_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stamp     (stamp_if),
		.cal       (cal_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic bit leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned year_len(input int unsigned y);
		return leap_year(y) ? 366 : 365;
	endfunction

	function automatic int unsigned month_len(input int unsigned y, input int unsigned m);
		case (m)
			1:            return leap_year(y) ? 29 : 28;
			3, 5, 8, 10:  return 30;
			default:      return 31;
		endcase
	endfunction

	function automatic cal_t to_calendar(input logic [ec_pkg::TIME_W-1:0] secs,
		input logic lcl, input logic [ec_pkg::ZONE_W-1:0] zone);
		logic [ec_pkg::TIME_W-1:0] t;
		int                        shift;
		int unsigned               days;
		int unsigned               yr;
		int unsigned               mo;
		cal_t                      c;
		t = secs;
		if (lcl) begin
			shift = $signed(zone) * SEC_PER_HOUR;
			t = secs + shift;
		end
		c.second = ec_pkg::SEC_W'(t % 60);
		t = t / 60;
		c.minute = ec_pkg::SEC_W'(t % 60);
		t = t / 60;
		c.hour = ec_pkg::HOUR_W'(t % 24);
		days = t / 24;
		c.weekday = ec_pkg::WDAY_W'((days + 4) % 7);
		yr = FIRST_YEAR;
		while (days >= year_len(yr)) begin
			days -= year_len(yr);
			yr++;
		end
		c.year_since_1900 = ec_pkg::YEAR_W'(yr - YEAR_BASE);
		c.day_of_year = ec_pkg::YDAY_W'(days);
		mo = 0;
		while (mo < 11 && days >= month_len(yr, mo)) begin
			days -= month_len(yr, mo);
			mo++;
		end
		c.month = ec_pkg::MON_W'(mo);
		c.day_of_month = ec_pkg::MDAY_W'(days + 1);
		return c;
	endfunction

	// idle with a chance of busy_pct percent; then mostly short, sometimes medium, rarely long
	function automatic int pick_idle(input int busy_pct);
		int r;
		if ($urandom_range(99) >= busy_pct)
			return 0;
		r = $urandom_range(99);
		if (r < 75)
			return $urandom_range(4, 1);
		if (r < 95)
			return $urandom_range(30, 5);
		return $urandom_range(300, 40);
	endfunction

	function automatic logic [ec_pkg::TIME_W-1:0] pick_stamp();
		logic [ec_pkg::TIME_W-1:0] base;
		case ($urandom_range(9))
			0: return $urandom_range(200000);
			1: return 32'hFFFF_FFFF - $urandom_range(200000);
			2: begin
				base = ($urandom / SEC_PER_DAY) * SEC_PER_DAY;
				return base - 32'd1 + $urandom_range(1);
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want,
		input logic [ec_pkg::TIME_W-1:0] stamp);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s mismatch for stamp %h: got %0d, expected %0d",
				$realtime, what, stamp, got, want);
	endtask

	task automatic check_beat();
		due_t want;
		if (pending.size() == 0) begin
			flag_mismatch("unexpected beat", 0, 0, 0);
			return;
		end
		want = pending.pop_front();
		if (cal_if.second != want.cal.second)
			flag_mismatch("second", cal_if.second, want.cal.second, want.stamp);
		if (cal_if.minute != want.cal.minute)
			flag_mismatch("minute", cal_if.minute, want.cal.minute, want.stamp);
		if (cal_if.hour != want.cal.hour)
			flag_mismatch("hour", cal_if.hour, want.cal.hour, want.stamp);
		if (cal_if.weekday != want.cal.weekday)
			flag_mismatch("weekday", cal_if.weekday, want.cal.weekday, want.stamp);
		if (cal_if.year_since_1900 != want.cal.year_since_1900)
			flag_mismatch("year_since_1900", cal_if.year_since_1900,
				want.cal.year_since_1900, want.stamp);
		if (cal_if.day_of_year != want.cal.day_of_year)
			flag_mismatch("day_of_year", cal_if.day_of_year, want.cal.day_of_year,
				want.stamp);
		if (cal_if.month != want.cal.month)
			flag_mismatch("month", cal_if.month, want.cal.month, want.stamp);
		if (cal_if.day_of_month != want.cal.day_of_month)
			flag_mismatch("day_of_month", cal_if.day_of_month, want.cal.day_of_month,
				want.stamp);
	endtask

	// result side: checks accepted beats, drives ready with random stalls and holds
	initial begin : sink_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (cal_if.valid && cal_if.ready)
				check_beat();
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end
			if (stall_left > 0) begin
				cal_if.ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = steady ? 0 : pick_idle(10);
				cal_if.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	task automatic send_stamp(input logic [ec_pkg::TIME_W-1:0] secs, input logic lcl);
		int   gap;
		due_t d;
		gap = steady ? 0 : pick_idle(50);
		if (gap > 0) begin
			stamp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stamp_if.valid <= 1'b1;
		stamp_if.epoch_seconds <= secs;
		stamp_if.to_local <= lcl;
		do @(posedge clk); while (!stamp_if.ready);
		d.stamp = secs;
		d.lcl = lcl;
		d.cal = to_calendar(secs, lcl, zone_now);
		pending.push_back(d);
	endtask

	task automatic wait_drain();
		stamp_if.valid <= 1'b0;
		do @(posedge clk); while (pending.size() != 0);
	endtask

	task automatic set_zone(input logic [ec_pkg::ZONE_W-1:0] z);
		wait_drain();
		cfg_we <= 1'b1;
		cfg_wdata <= z;
		@(posedge clk);
		cfg_we <= 1'b0;
		zone_now = z;
	endtask

	// calendar corners under the reset zone, both UTC and local
	task automatic test_directed();
		logic [ec_pkg::TIME_W-1:0] marks [10];
		marks = '{32'd0, 32'd951782400, 32'd951868799, 32'd978307199, 32'd1709164800,
			32'd2147483647, 32'd4102444799, 32'd4107542399, 32'd4107542400,
			32'hFFFF_FFFF};
		foreach (marks[i]) begin
			send_stamp(marks[i], 1'b0);
			send_stamp(marks[i], 1'b1);
		end
	endtask

	// offsets beyond the nominal range, wrapping past both ends of the time range
	task automatic test_zone_wrap();
		set_zone(ec_pkg::ZONE_W'(-16));
		send_stamp(32'd0, 1'b1);
		send_stamp(32'd57599, 1'b1);
		send_stamp(32'd57600, 1'b1);
		set_zone(ec_pkg::ZONE_W'(15));
		send_stamp(32'hFFFF_FFFF - 32'd53999, 1'b1);
		send_stamp(32'hFFFF_FFFF - 32'd54000, 1'b1);
	endtask

	task automatic test_random(input int count);
		repeat (count) send_stamp(pick_stamp(), 1'($urandom_range(1)));
	endtask

	// receiver holds off while beats keep coming, so the input stalls
	task automatic test_output_hold();
		wait_drain();
		hold_req = HOLD_CYCLES;
		test_random(24);
		wait_drain();
	endtask

	task automatic test_back_to_back();
		wait_drain();
		steady = 1'b1;
		test_random(60);
		wait_drain();
		steady = 1'b0;
	endtask

	task automatic test_drain_pause();
		repeat (3) begin
			test_random(10);
			wait_drain();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		stamp_if.valid <= 1'b0;
		stamp_if.epoch_seconds <= '0;
		stamp_if.to_local <= 1'b0;
		cal_if.ready <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_zone_wrap();
		set_zone(ec_pkg::ZONE_W'(-12));
		test_random(180);
		set_zone(ec_pkg::ZONE_W'(14));
		test_random(180);
		set_zone(ec_pkg::ZONE_W'(0));
		test_random(180);
		test_output_hold();
		test_back_to_back();
		test_drain_pause();
		repeat (5) begin
			set_zone(ec_pkg::ZONE_W'($urandom_range(31)));
			test_random(150);
		end

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending.size() != 0)
			flag_mismatch("missing beats", 0, pending.size(), 0);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
